[src/assert_macros.svh]
// Assertion macros shared by the detector modules.
// No dependencies; each macro checks on the rising edge and is quiet in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset
`define MTLP_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Antecedent in one cycle implies consequent in the same cycle
`define MTLP_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next cycle
`define MTLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/mtlp_pkg.sv]
// Types, constants and helper functions for the multi-tap / long-press detector.
// No dependencies.
`timescale 1ns / 1ps

package mtlp_pkg;

    localparam int KEY_LEVELS_W = 8;
    localparam int KEY_STATUS_W = 16;
    localparam int TAP_COUNTS_W = 32;
    localparam int CNT_W        = 8;
    localparam int TAP_W        = 4;
    localparam int STATUS_W     = 2;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 8;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_THRESHOLD = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TAP_WINDOW     = 1'd1;

    localparam logic [CNT_W-1:0] HOLD_THRESHOLD_RST = 8'd32;
    localparam logic [CNT_W-1:0] TAP_WINDOW_RST     = 8'd64;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [TAP_W-1:0] TAP_MAX = {TAP_W{1'b1}};

    typedef enum logic [STATUS_W-1:0] {
        PS_RELEASED = 2'd0,
        PS_PRESSED  = 2'd1,
        PS_HELD     = 2'd2
    } press_state_t;

    // Thresholds handed to every lane
    typedef struct packed {
        logic [CNT_W-1:0] hold_threshold;
        logic [CNT_W-1:0] tap_window;
    } mtlp_cfg_t;

    function automatic logic [CNT_W-1:0] sat_inc8(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

    function automatic logic [TAP_W-1:0] sat_inc4(input logic [TAP_W-1:0] v);
        return (v == TAP_MAX) ? TAP_MAX : v + 1'b1;
    endfunction

endpackage

[src/mtlp_if.sv]
// Valid/ready channel interfaces for the detector's tick input and result output.
// Depends on mtlp_pkg for the field widths.
`timescale 1ns / 1ps

interface mtlp_in_if import mtlp_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [KEY_LEVELS_W-1:0] key_levels;

    modport source (output valid, output key_levels, input ready);
    modport sink   (input valid, input key_levels, output ready);
endinterface

interface mtlp_out_if import mtlp_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [KEY_STATUS_W-1:0] key_status;
    logic [TAP_COUNTS_W-1:0] tap_counts;

    modport source (output valid, output key_status, output tap_counts, input ready);
    modport sink   (input valid, input key_status, input tap_counts, output ready);
endinterface

[src/mtlp_lane.sv]
// One key lane: press state, hold counter, tap counter, gap timer and latch.
// Depends on mtlp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mtlp_lane import mtlp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                update,
    input  logic                down,
    input  mtlp_cfg_t           cfg,
    output press_state_t        status_next,
    output logic [TAP_W-1:0]    taps_next
);

    press_state_t       press_state_reg;
    logic [CNT_W-1:0]   hold_ticks_reg;
    logic [TAP_W-1:0]   tap_count_reg;
    logic [CNT_W-1:0]   gap_ticks_reg;
    logic               press_latched_reg;

    press_state_t       press_state_next;
    logic [CNT_W-1:0]   hold_ticks_next;
    logic [TAP_W-1:0]   tap_count_next;
    logic [CNT_W-1:0]   gap_ticks_next;
    logic               press_latched_next;

    // Tick update: gap timeout first, then press handling, then release
    always_comb
    begin
        logic [CNT_W-1:0] gap_s1;
        logic [TAP_W-1:0] tap_s1;
        logic [CNT_W-1:0] hold_inc;

        gap_s1 = gap_ticks_reg;
        tap_s1 = tap_count_reg;
        if (tap_count_reg != '0)
        begin
            gap_s1 = sat_inc8(gap_ticks_reg);
            if ((gap_s1 > cfg.tap_window) && (press_state_reg == PS_RELEASED))
            begin
                gap_s1 = '0;
                tap_s1 = '0;
            end
        end

        press_state_next   = press_state_reg;
        hold_ticks_next    = hold_ticks_reg;
        tap_count_next     = tap_s1;
        gap_ticks_next     = gap_s1;
        press_latched_next = press_latched_reg;
        hold_inc           = sat_inc8(hold_ticks_reg);

        if (down)
        begin
            press_state_next = PS_PRESSED;
            if (tap_s1 == '0)
            begin
                // first tap of a sequence
                tap_count_next     = {{(TAP_W-1){1'b0}}, 1'b1};
                hold_ticks_next    = '0;
                gap_ticks_next     = '0;
                press_latched_next = 1'b1;
            end
            else
            begin
                if (!press_latched_reg)
                begin
                    tap_count_next     = sat_inc4(tap_s1);
                    gap_ticks_next     = '0;
                    press_latched_next = 1'b1;
                end
                hold_ticks_next = hold_inc;
                if (hold_inc > cfg.hold_threshold)
                begin
                    press_state_next = PS_HELD;
                end
            end
        end
        else if (press_state_reg != PS_RELEASED)
        begin
            press_state_next   = PS_RELEASED;
            hold_ticks_next    = '0;
            press_latched_next = 1'b0;
        end
    end

    // Lane state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_state_reg   <= PS_RELEASED;
            hold_ticks_reg    <= '0;
            tap_count_reg     <= '0;
            gap_ticks_reg     <= '0;
            press_latched_reg <= 1'b0;
        end
        else if (update)
        begin
            press_state_reg   <= press_state_next;
            hold_ticks_reg    <= hold_ticks_next;
            tap_count_reg     <= tap_count_next;
            gap_ticks_reg     <= gap_ticks_next;
            press_latched_reg <= press_latched_next;
        end
    end

    assign status_next = press_state_next;
    assign taps_next   = tap_count_next;

    // latch and press state are set and cleared together
    `MTLP_ASSERT_ALWAYS(a_latch_tracks_press, clk, rst_n, press_latched_reg == (press_state_reg != PS_RELEASED))
    // a latched press always has at least one tap pending
    `MTLP_ASSERT_IMPLIES(a_latch_has_tap, clk, rst_n, press_latched_reg, tap_count_reg != '0)
    // held long means the hold counter has moved
    `MTLP_ASSERT_IMPLIES(a_held_has_ticks, clk, rst_n, press_state_reg == PS_HELD, hold_ticks_reg != '0)

endmodule

[src/multi_tap_long_press_detector.sv]
// Multi-tap / long-press detector. Each input item is one tick carrying the
// level of every key; each tick gives exactly one result item with the press
// state (2 bits per key) and tap count (4 bits per key) after that tick. A new
// tick is taken every clock cycle unless the result stalls; ticks pass input
// register, lanes and result register. hold_threshold (index 0, reset 32)
// and tap_window (index 1, reset 64) are written through the cfg port only
// while no tick is in flight; the user must ensure this, as the block does
// not enforce it. Only the first eight keys are seen; missing keys report
// zero. Depends on mtlp_pkg, mtlp_if, mtlp_lane and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multi_tap_long_press_detector import mtlp_pkg::*;
#(
    parameter int NUM_KEYS = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    mtlp_in_if.sink                in_ch,
    mtlp_out_if.source             out_ch,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // only keys that reach the input field and outputs get a lane
    localparam int LANES = (NUM_KEYS < KEY_LEVELS_W) ? NUM_KEYS : KEY_LEVELS_W;

    mtlp_cfg_t               cfg_reg;
    logic                    in_valid_reg;
    logic [KEY_LEVELS_W-1:0] levels_reg;
    logic                    out_valid_reg;
    logic [KEY_STATUS_W-1:0] status_reg;
    logic [TAP_COUNTS_W-1:0] taps_reg;

    logic                    advance;
    logic                    update;
    logic [KEY_STATUS_W-1:0] status_next;
    logic [TAP_COUNTS_W-1:0] taps_next;
    press_state_t            lane_status [LANES];
    logic [TAP_W-1:0]        lane_taps   [LANES];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_threshold <= HOLD_THRESHOLD_RST;
            cfg_reg.tap_window     <= TAP_WINDOW_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HOLD_THRESHOLD: cfg_reg.hold_threshold <= cfg_data;
                REG_TAP_WINDOW:     cfg_reg.tap_window     <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Handshake: result register frees up, input register moves forward
    assign advance      = !out_valid_reg || out_ch.ready;
    assign update       = advance && in_valid_reg;
    assign in_ch.ready  = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            levels_reg <= in_ch.key_levels;
        end
    end

    // Key lanes
    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        mtlp_lane u_lane
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .update      (update),
            .down        (levels_reg[k]),
            .cfg         (cfg_reg),
            .status_next (lane_status[k]),
            .taps_next   (lane_taps[k])
        );
    end

    // Pack lane results into the output fields
    always_comb
    begin
        status_next = '0;
        taps_next   = '0;
        for (int k = 0; k < LANES; k++)
        begin
            status_next[STATUS_W*k +: STATUS_W] = lane_status[k];
            taps_next[TAP_W*k +: TAP_W]         = lane_taps[k];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (update)
        begin
            status_reg <= status_next;
            taps_reg   <= taps_next;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.key_status = status_reg;
    assign out_ch.tap_counts = taps_reg;

    // a tick waiting behind a stalled result is kept
    `MTLP_ASSERT_NEXT(a_in_held, clk, rst_n, in_valid_reg && !advance, in_valid_reg)
    // a stalled result keeps its payload while the lanes stand still
    `MTLP_ASSERT_NEXT(a_out_frozen, clk, rst_n, out_valid_reg && !out_ch.ready, $stable(status_reg) && $stable(taps_reg))
    // lanes only update when a result slot is free
    `MTLP_ASSERT_IMPLIES(a_update_slot, clk, rst_n, update, !out_valid_reg || out_ch.ready)

endmodule

[bench/tb_multi_tap_long_press_detector.sv]
// Self-checking bench for multi_tap_long_press_detector: key-level ticks in, press/tap reports out.
// Depends on mtlp_pkg and the mtlp_in_if / mtlp_out_if channel interfaces of the RTL.
`timescale 1ns / 1ps

import mtlp_pkg::*;

// Tracks every key lane in step with the block and checks each report item
class key_lane_tracker;

    typedef struct packed {
        logic [KEY_STATUS_W-1:0] status;
        logic [TAP_COUNTS_W-1:0] taps;
    } lane_report_t;

    press_state_t     lane_state [KEY_LEVELS_W];
    logic [CNT_W-1:0] held_for   [KEY_LEVELS_W];
    logic [TAP_W-1:0] tap_tally  [KEY_LEVELS_W];
    logic [CNT_W-1:0] since_tap  [KEY_LEVELS_W];
    bit               latched    [KEY_LEVELS_W];
    logic [CNT_W-1:0] hold_limit;
    logic [CNT_W-1:0] window;
    lane_report_t     due_reports [$];
    int               errors;

    function new();
        hold_limit = HOLD_THRESHOLD_RST;
        window     = TAP_WINDOW_RST;
        errors     = 0;
        for (int k = 0; k < KEY_LEVELS_W; k++)
        begin
            lane_state[k] = PS_RELEASED;
            held_for[k]   = '0;
            tap_tally[k]  = '0;
            since_tap[k]  = '0;
            latched[k]    = 1'b0;
        end
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        if (idx == REG_HOLD_THRESHOLD)
            hold_limit = val;
        else if (idx == REG_TAP_WINDOW)
            window = val;
    endfunction

    // One tick: advance all lanes and queue the report they give
    function void note_tick(logic [KEY_LEVELS_W-1:0] levels);
        lane_report_t rep;
        rep = '0;
        for (int k = 0; k < KEY_LEVELS_W; k++)
        begin
            // gap timer, and clearing of stale taps while released
            if (tap_tally[k] != 0)
            begin
                if (since_tap[k] != {CNT_W{1'b1}})
                    since_tap[k] = since_tap[k] + 1'b1;
                if (since_tap[k] > window && lane_state[k] == PS_RELEASED)
                begin
                    since_tap[k] = '0;
                    tap_tally[k] = '0;
                end
            end
            if (levels[k])
            begin
                lane_state[k] = PS_PRESSED;
                if (tap_tally[k] == 0)
                begin
                    // first tap of a burst
                    tap_tally[k] = {{(TAP_W-1){1'b0}}, 1'b1};
                    held_for[k]  = '0;
                    latched[k]   = 1'b1;
                    since_tap[k] = '0;
                end
                else
                begin
                    if (!latched[k])
                    begin
                        if (tap_tally[k] != {TAP_W{1'b1}})
                            tap_tally[k] = tap_tally[k] + 1'b1;
                        since_tap[k] = '0;
                        latched[k]   = 1'b1;
                    end
                    if (held_for[k] != {CNT_W{1'b1}})
                        held_for[k] = held_for[k] + 1'b1;
                    if (held_for[k] > hold_limit)
                        lane_state[k] = PS_HELD;
                end
            end
            else if (lane_state[k] != PS_RELEASED)
            begin
                lane_state[k] = PS_RELEASED;
                held_for[k]   = '0;
                latched[k]    = 1'b0;
            end
            rep.status[2*k +: 2] = lane_state[k];
            rep.taps[4*k +: 4]   = tap_tally[k];
        end
        due_reports.push_back(rep);
    endfunction

    function void check_result(logic [KEY_STATUS_W-1:0] status,
                               logic [TAP_COUNTS_W-1:0] taps);
        lane_report_t want;
        if (due_reports.size() == 0)
        begin
            errors++;
            $display("%0t: report item with none due: status %h taps %h", $time, status, taps);
            return;
        end
        want = due_reports.pop_front();
        if (status !== want.status)
        begin
            errors++;
            $display("%0t: key_status expected %h actual %h", $time, want.status, status);
        end
        if (taps !== want.taps)
        begin
            errors++;
            $display("%0t: tap_counts expected %h actual %h", $time, want.taps, taps);
        end
    endfunction

    function int pending();
        return due_reports.size();
    endfunction
endclass

module tb_multi_tap_long_press_detector;
    import mtlp_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    mtlp_in_if  tick_ch ();
    mtlp_out_if report_ch ();

    key_lane_tracker tracker = new();

    // stimulus knobs, some shared with the receiver
    bit idle_on   = 1'b1;
    int long_hold = 0;
    int cur_thr   = HOLD_THRESHOLD_RST;
    int cur_win   = TAP_WINDOW_RST;

    // per-key run lengths for well-formed press/release patterns
    bit key_down  [KEY_LEVELS_W];
    int span_left [KEY_LEVELS_W];

    logic [KEY_LEVELS_W-1:0] opening_ticks [20] = '{
        8'h00, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h01, 8'h01,
        8'hAA, 8'h55, 8'hAA, 8'h00, 8'h80, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00
    };

    multi_tap_long_press_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (tick_ch),
        .out_ch    (report_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("multi_tap_long_press_detector test failed");
        $finish;
    end

    // accepted items on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tick_ch.valid && tick_ch.ready)
                tracker.note_tick(tick_ch.key_levels);
            if (report_ch.valid && report_ch.ready)
                tracker.check_result(report_ch.key_status, report_ch.tap_counts);
        end
    end

    // receiver: short random stalls, or one long hold-off on request
    initial
    begin
        report_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold > 0)
            begin
                report_ch.ready <= 1'b0;
                repeat (long_hold) @(posedge clk);
                long_hold = 0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                report_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                report_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic offer_tick(input logic [KEY_LEVELS_W-1:0] levels);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        tick_ch.valid      <= 1'b1;
        tick_ch.key_levels <= levels;
        @(posedge clk);
        while (!tick_ch.ready) @(posedge clk);
    endtask

    // let every report come back, then wait idle
    task automatic drain();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        tracker.write_reg(idx, val[CFG_DATA_W-1:0]);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_thresholds(input int thr, input int win);
        drain();
        write_reg(REG_HOLD_THRESHOLD, thr);
        write_reg(REG_TAP_WINDOW, win);
        cur_thr = thr;
        cur_win = win;
    endtask

    // press or release length, clustered around the thresholds
    function automatic int pick_span(bit long_mode);
        int sel;
        sel = $urandom_range(0, 5);
        if (long_mode && sel == 5)
            return $urandom_range(256, 290);
        case (sel)
            0: return $urandom_range(1, 2);
            1: return cur_thr + $urandom_range(0, 2) + 1;
            2: return cur_win + $urandom_range(0, 3) + 1;
            3: return $urandom_range(1, 8);
            4: return $urandom_range(1, 3);
            default: return $urandom_range(4, 20);
        endcase
    endfunction

    task automatic run_phase(input int count, input bit long_mode);
        logic [KEY_LEVELS_W-1:0] levels;
        for (int i = 0; i < count; i++)
        begin
            for (int k = 0; k < KEY_LEVELS_W; k++)
            begin
                if (span_left[k] <= 0)
                begin
                    key_down[k]  = !key_down[k];
                    span_left[k] = pick_span(long_mode);
                end
                span_left[k]--;
                levels[k] = key_down[k];
            end
            // occasional noise tick
            if ($urandom_range(0, 7) == 0)
                levels = KEY_LEVELS_W'($urandom_range(0, 255));
            offer_tick(levels);
        end
    endtask

    initial
    begin
        tick_ch.valid      <= 1'b0;
        tick_ch.key_levels <= '0;
        cfg_we             <= 1'b0;
        cfg_index          <= REG_HOLD_THRESHOLD;
        cfg_data           <= '0;
        for (int k = 0; k < KEY_LEVELS_W; k++)
        begin
            key_down[k]  = 1'b0;
            span_left[k] = 0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed ticks at reset thresholds
        foreach (opening_ticks[i])
            offer_tick(opening_ticks[i]);
        run_phase(150, 1'b0);

        // zero thresholds: held on second tick, taps clear at once
        set_thresholds(0, 0);
        run_phase(120, 1'b0);

        // short thresholds: fast taps saturate the tap count
        set_thresholds(3, 6);
        run_phase(200, 1'b0);

        set_thresholds(1, 2);
        run_phase(120, 1'b0);

        // top of range: long holds saturate hold and gap counters
        set_thresholds(254, 254);
        run_phase(320, 1'b1);
        set_thresholds(255, 255);
        run_phase(320, 1'b1);

        // receiver holds off while ticks keep coming, so the block backs up
        set_thresholds(10, 30);
        long_hold = 50;
        run_phase(150, 1'b0);

        // last part: random thresholds, no idling on either side
        set_thresholds($urandom_range(0, 255), $urandom_range(0, 255));
        idle_on = 1'b0;
        run_phase(100, 1'b0);

        drain();
        repeat (8) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("multi_tap_long_press_detector test passed");
        else
            $display("multi_tap_long_press_detector test failed");
        $finish;
    end
endmodule

[sim.f]
+incdir+src
src/mtlp_pkg.sv
src/mtlp_if.sv
src/mtlp_lane.sv
src/multi_tap_long_press_detector.sv
bench/tb_multi_tap_long_press_detector.sv
